FILE: hw/rtl/recx_pkg.sv
// ============================================================================
// recx_pkg
// Shared widths, limits, register codes and the control/status bundles of
// the row edge centroid extractor.
// ============================================================================
package recx_pkg;

   localparam int MAX_COLUMNS = 2048;
   localparam int MAX_ROWS    = 4096;
   localparam int POINT_LIMIT = 8192;

   localparam int PIXEL_W  = 8;
   localparam int COL_W    = 11;
   localparam int ROW_W    = 12;
   localparam int SUM_W    = 21;
   localparam int CNT_W    = 12;
   localparam int PCNT_W   = 14;
   localparam int XOFF_W   = 11;
   localparam int YOFF_W   = 12;
   localparam int PX_W     = 12;
   localparam int PY_W     = 13;
   localparam int REM_W    = CNT_W + 1;
   localparam int STEP_W   = 5;

   localparam int RSP_DATA_W = 40;
   localparam int REQ_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(MAX_COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(MAX_ROWS - 1);
   localparam logic [PCNT_W-1:0] PT_LIMIT    = PCNT_W'(POINT_LIMIT);
   localparam logic [STEP_W-1:0] DIV_STEPS   = STEP_W'(SUM_W);

   // register index, taken from paddr[2]
   localparam logic REG_X_BASE = 1'b0;
   localparam logic REG_Y_BASE = 1'b1;

   typedef struct packed {
      logic accept;      // input transfer this cycle
      logic load_point;  // load point result into output register
      logic load_total;  // load frame total into output register
   } recx_cmd_type;

   typedef struct packed {
      logic has_point;   // current input closes a row that gives a point
      logic frame_end;   // current input ends the frame
      logic frame_pend;  // item being worked on ended the frame
      logic div_busy;
      logic out_free;    // output register can take a result
   } recx_status_type;

endpackage

FILE: hw/rtl/recx_div.sv
// ============================================================================
// recx_div
// Restoring divider, one quotient bit per cycle, used for the row mean.
// ============================================================================
module recx_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [recx_pkg::SUM_W-1:0]   dividend,
   input  logic [recx_pkg::CNT_W-1:0]   divisor,
   output logic                         busy,
   output logic [recx_pkg::COL_W-1:0]   quotient
);
   import recx_pkg::*;

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]  trial;

   assign trial = {rem_ff[REM_W-2:0], quo_ff[SUM_W-1]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         step_in = DIV_STEPS;
      end else if (step_ff != '0) begin
         step_in = step_ff - STEP_W'(1);
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (step_ff != '0);
   // mean column never exceeds the last column index
   assign quotient = quo_ff[COL_W-1:0];

endmodule

FILE: hw/rtl/recx_dp.sv
// ============================================================================
// recx_dp
// Datapath: column/row tracking, per-row sums, point bookkeeping, mean
// divider and the output register.
// ============================================================================
module recx_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  recx_pkg::recx_cmd_type            cmd,
   output recx_pkg::recx_status_type         status,
   input  logic [recx_pkg::PIXEL_W-1:0]      pixel,
   input  logic                              row_end,
   input  logic                              frame_end,
   input  logic [recx_pkg::XOFF_W-1:0]       x_base,
   input  logic [recx_pkg::YOFF_W-1:0]       y_base,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [recx_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser
);
   import recx_pkg::*;

   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SUM_W-1:0]  sum_ff, sum_in, sum_new;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_new;
   logic [PCNT_W-1:0] pcount_ff, pcount_in, pcount_inc;
   logic              limit_ff, limit_in;
   logic              overrun_ff, overrun_in;
   logic              frame_pend_ff;
   logic [PY_W-1:0]   py_ff;
   logic [PCNT_W-1:0] ptot_ff, stot_ff;

   logic              is_edge, row_done, has_point;
   logic              div_busy;
   logic [COL_W-1:0]  mean_col;

   logic              valid_ff;
   logic              summ_ff, last_ff;
   logic [PX_W-1:0]   ox_ff;
   logic [PY_W-1:0]   oy_ff;
   logic [PCNT_W-1:0] otot_ff;

   assign is_edge    = !overrun_ff && (pixel != '0);
   assign sum_new    = is_edge ? sum_ff + SUM_W'(column_ff) : sum_ff;
   assign cnt_new    = is_edge ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign row_done   = row_end || frame_end;
   assign has_point  = row_done && (cnt_new != '0) && !limit_ff;
   assign pcount_inc = pcount_ff + PCNT_W'(1);

   recx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept && has_point),
      .dividend (sum_new),
      .divisor  (cnt_new),
      .busy     (div_busy),
      .quotient (mean_col)
   );

   always_comb begin
      column_in  = column_ff;
      row_in     = row_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      pcount_in  = pcount_ff;
      limit_in   = limit_ff;
      overrun_in = overrun_ff;
      if (cmd.accept) begin
         if (row_done) begin
            column_in  = '0;
            sum_in     = '0;
            cnt_in     = '0;
            overrun_in = 1'b0;
            if (row_ff != LAST_ROW) begin
               row_in = row_ff + ROW_W'(1);
            end
            if (has_point) begin
               pcount_in = pcount_inc;
               limit_in  = (pcount_inc >= PT_LIMIT);
            end
         end else begin
            sum_in = sum_new;
            cnt_in = cnt_new;
            if (column_ff == LAST_COL) begin
               overrun_in = 1'b1;
            end else begin
               column_in = column_ff + COL_W'(1);
            end
         end
         if (frame_end) begin
            row_in    = '0;
            pcount_in = '0;
            limit_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         pcount_ff     <= '0;
         limit_ff      <= 1'b0;
         overrun_ff    <= 1'b0;
         frame_pend_ff <= 1'b0;
      end else begin
         column_ff  <= column_in;
         row_ff     <= row_in;
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         pcount_ff  <= pcount_in;
         limit_ff   <= limit_in;
         overrun_ff <= overrun_in;
         if (cmd.accept) begin
            frame_pend_ff <= frame_end;
         end
      end
      if (cmd.accept) begin
         py_ff   <= PY_W'(row_ff) + PY_W'(y_base);
         ptot_ff <= pcount_inc;
         stot_ff <= has_point ? pcount_inc : pcount_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_point || cmd.load_total) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.load_point) begin
         summ_ff <= 1'b0;
         ox_ff   <= PX_W'(mean_col) + PX_W'(x_base);
         oy_ff   <= py_ff;
         otot_ff <= ptot_ff;
         last_ff <= !frame_pend_ff;
      end else if (cmd.load_total) begin
         summ_ff <= 1'b1;
         ox_ff   <= '0;
         oy_ff   <= '0;
         otot_ff <= stot_ff;
         last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, otot_ff, oy_ff, ox_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = summ_ff;

   assign status.has_point  = has_point;
   assign status.frame_end  = frame_end;
   assign status.frame_pend = frame_pend_ff;
   assign status.div_busy   = div_busy;
   assign status.out_free   = !valid_ff || rsp_tready;

endmodule

FILE: hw/rtl/recx_ctrl.sv
// ============================================================================
// recx_ctrl
// Controller: takes pixels, waits out the mean division and sequences the
// point and frame-total results into the output register.
// ============================================================================
module recx_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  recx_pkg::recx_status_type   status,
   output recx_pkg::recx_cmd_type      cmd
);
   import recx_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_POINT  = 4'b0100,
      ST_TOTAL  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = accept;
      cmd.load_point = 1'b0;
      cmd.load_total = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (status.has_point) begin
                  state_in = ST_DIVIDE;
               end else if (status.frame_end) begin
                  state_in = ST_TOTAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            if (status.out_free) begin
               cmd.load_point = 1'b1;
               state_in = status.frame_pend ? ST_TOTAL : ST_IDLE;
            end
         end
         ST_TOTAL: begin
            if (status.out_free) begin
               cmd.load_total = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/row_edge_centroid_extractor_core.sv
// ============================================================================
// row_edge_centroid_extractor_core
// Per-row edge pixel centroid extractor with APB-style base registers.
// ============================================================================
// Pixels of an edge map come in raster order, one transfer per cycle while
// no point or frame total is pending; tlast marks the last pixel of a row
// and tuser the last pixel of the frame. A pixel that closes a row with
// edge pixels, below the point limit, starts a restoring division of the
// column sum by the edge count; tready then stays low until the point, and
// the frame total when one follows, is loaded, and after a frame end without
// a point until the total is loaded. Output stalls lengthen these waits.
// Results leave through an output register: a point (tuser 0) carries mean
// column plus the x base, row plus the y base and the running point count;
// at frame end a total (tuser 1) follows with the frame's point count.
// Registers: x base at byte address 0, y base at byte address 4.
module row_edge_centroid_extractor_core (
   input  logic                                clock,
   input  logic                                reset,
   // stream in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [recx_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] pixel
   input  logic                                req_tlast,  // row_end
   input  logic                                req_tuser,  // frame_end
   // stream out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] point_x, [24:12] point_y, [38:25] points_total, [39] zero
   output logic [recx_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,  // is_last
   output logic                                rsp_tuser,  // is_summary
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [recx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [recx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [recx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import recx_pkg::*;

   logic [XOFF_W-1:0] x_base_ff;
   logic [YOFF_W-1:0] y_base_ff;
   logic              csr_write;
   logic              reg_sel;

   recx_cmd_type      cmd;
   recx_status_type   status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x_base_ff <= '0;
         y_base_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_X_BASE: x_base_ff <= csr_pwdata[XOFF_W-1:0];
            REG_Y_BASE: y_base_ff <= csr_pwdata[YOFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_X_BASE: csr_prdata = CSR_DATA_W'(x_base_ff);
         REG_Y_BASE: csr_prdata = CSR_DATA_W'(y_base_ff);
         default:    csr_prdata = '0;
      endcase
   end

   recx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   recx_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .pixel      (req_tdata[PIXEL_W-1:0]),
      .row_end    (req_tlast),
      .frame_end  (req_tuser),
      .x_base     (x_base_ff),
      .y_base     (y_base_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a frame end always owes a total, so the input side must stall
   a_frame_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input taken right after frame end");

   a_total_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[24:0] == 25'd0))
      else $error("frame total malformed");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_point || cmd.load_total) |-> !status.div_busy && status.out_free)
      else $error("result loaded into occupied output register");

endmodule
